FILE: src/bpla_pkg.sv
// package: shared types, register indexes and reset values for the beat pulse light assigner
`timescale 1ns / 1ps
`default_nettype none
package bpla_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 8;

  localparam logic [CfgIndexWidth-1:0] CFG_MAG_THRESHOLD = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_SPR_THRESHOLD = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_DECAY_RELOAD  = 2'd2;

  localparam logic [7:0] MAG_THRESHOLD_RST = 8'd210;
  localparam logic [7:0] SPR_THRESHOLD_RST = 8'd212;
  localparam logic [7:0] DECAY_RELOAD_RST  = 8'd8;

  localparam int unsigned InDataWidth  = 64;
  localparam int unsigned OutDataWidth = 24;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TEST,
    S_CLAIM,
    S_EMIT
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // load the bin request into the input registers
    logic test;    // threshold test and run tracking on the held bin
    logic emit;    // resolve one light and load its status
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic final_bin;  // held bin closes the frame
    logic out_free;   // status register can take a new value
    logic emit_last;  // light being resolved is the last one
  } status_t;

endpackage
`default_nettype wire

FILE: src/beat_pulse_light_assigner.sv
// top level: beat pulse light assigner with bin stream in, light status stream out
//
// usage
//   the slave stream carries the spectrum bins of one frame in bin order; tlast
//   marks the final bin and tuser carries the frame clipped flag with it
//   each bin is handled in its accept cycle and then a threshold test cycle in
//   which the bin's run tracking is updated; tready is high only while idle
//   a pulse found on a bin is matched against the owned lights in the cycle after
//   its test, or else queued as free for the frame-end pass
//   after the final bin the block emits NUM_LAMPS light status requests on the
//   master stream, tlast on the last; the first is registered after the test and
//   claim states, then one per cycle while the receiver keeps tready high
//   one status is resolved per cycle by the light ring, so a stall on the master
//   side holds the status register and pauses the ring; the next frame's first
//   bin can be taken as soon as the last status sits in the register
//   configuration writes take effect at once and belong in idle periods
//   reset restores the threshold defaults, releases every light and clears all
//   run tracking; there is no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module beat_pulse_light_assigner #(
  parameter int unsigned NUM_BINS  = 64,
  parameter int unsigned NUM_LAMPS = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // bin_magnitude[15:0], bin_spread[31:16], frame_magnitude_max[47:32],
  // frame_spread_max[63:48]
  input  wire logic [bpla_pkg::InDataWidth-1:0]      s_axis_tdata_i,
  // frame_clipped[0]
  input  wire logic [0:0]                            s_axis_tuser_i,
  input  wire logic                                  s_axis_tlast_i,
  input  wire logic                                  s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // light_index[2:0], light_on[3], light_owned[4], light_bin[10:5],
  // decay_left[18:11], zero[23:19]
  output logic [bpla_pkg::OutDataWidth-1:0]          m_axis_tdata_o,
  output logic                                       m_axis_tlast_o,
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  input  wire logic                                  cfg_we_i,
  input  wire logic [bpla_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  wire logic [bpla_pkg::CfgDataWidth-1:0]     cfg_data_i
);
  import bpla_pkg::*;

  localparam int unsigned BinWidth = $clog2(NUM_BINS);

  // configuration registers
  logic [7:0] mag_thr_q, spr_thr_q, reload_q;

  cmd_t    cmd;
  status_t status;

  logic                pulse_valid;
  logic [BinWidth-1:0] pulse_bin;
  logic                frame_clipped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_thr_q <= MAG_THRESHOLD_RST;
      spr_thr_q <= SPR_THRESHOLD_RST;
      reload_q  <= DECAY_RELOAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAG_THRESHOLD: mag_thr_q <= cfg_data_i;
        CFG_SPR_THRESHOLD: spr_thr_q <= cfg_data_i;
        CFG_DECAY_RELOAD:  reload_q  <= cfg_data_i;
        default: ;  // no register at this index
      endcase
    end
  end

  // sequencing of bin intake and status emission
  bpla_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  // threshold test and pulse detection
  bpla_bin_scan #(
    .NUM_BINS (NUM_BINS)
  ) u_bin_scan (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .bin_magnitude_i       (s_axis_tdata_i[15:0]),
    .bin_spread_i          (s_axis_tdata_i[31:16]),
    .frame_magnitude_max_i (s_axis_tdata_i[47:32]),
    .frame_spread_max_i    (s_axis_tdata_i[63:48]),
    .frame_clipped_i       (s_axis_tuser_i[0]),
    .final_bin_i           (s_axis_tlast_i),
    .magnitude_threshold_i (mag_thr_q),
    .spread_threshold_i    (spr_thr_q),
    .final_bin_o           (status.final_bin),
    .frame_clipped_o       (frame_clipped),
    .pulse_valid_o         (pulse_valid),
    .pulse_bin_o           (pulse_bin)
  );

  // light ownership and status output
  bpla_lights #(
    .NUM_BINS  (NUM_BINS),
    .NUM_LAMPS (NUM_LAMPS)
  ) u_lights (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .emit_i          (cmd.emit),
    .pulse_valid_i   (pulse_valid),
    .pulse_bin_i     (pulse_bin),
    .frame_clipped_i (frame_clipped),
    .decay_reload_i  (reload_q),
    .out_free_o      (status.out_free),
    .emit_last_o     (status.emit_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // a bin request is always followed by its test cycle
  a_bin_then_test : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("bin request taken during its own test cycle");

  // statuses of one frame follow each other without a gap
  a_status_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=> m_axis_tvalid_o)
    else $error("gap inside a light status burst");

  // light numbers step by one within a burst
  a_status_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o)
    |=> (m_axis_tdata_o[2:0] == $past(m_axis_tdata_o[2:0]) + 3'd1))
    else $error("light status out of order");

endmodule
`default_nettype wire

FILE: src/bpla_ctrl.sv
// controller state machine: bin intake, frame-end claim and light status sequencing
`timescale 1ns / 1ps
`default_nettype none
module bpla_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire bpla_pkg::status_t status_i,
  output bpla_pkg::cmd_t         cmd_o
);
  import bpla_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        state_d = status_i.final_bin ? S_CLAIM : S_IDLE;
      end
      S_CLAIM: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free && status_i.emit_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    cmd_o           = '0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.accept    = s_axis_tvalid_i;
      end
      S_TEST: begin
        cmd_o.test = 1'b1;
      end
      S_CLAIM: begin
        cmd_o = '0;
      end
      S_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/bpla_bin_scan.sv
// datapath: bin threshold test and on-the-fly run tracking that yields pulse bins
`timescale 1ns / 1ps
`default_nettype none
module bpla_bin_scan #(
  parameter int unsigned NUM_BINS = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bpla_pkg::cmd_t              cmd_i,
  input  wire logic [15:0]                 bin_magnitude_i,
  input  wire logic [15:0]                 bin_spread_i,
  input  wire logic [15:0]                 frame_magnitude_max_i,
  input  wire logic [15:0]                 frame_spread_max_i,
  input  wire logic                        frame_clipped_i,
  input  wire logic                        final_bin_i,
  input  wire logic [7:0]                  magnitude_threshold_i,
  input  wire logic [7:0]                  spread_threshold_i,
  output logic                             final_bin_o,
  output logic                             frame_clipped_o,
  output logic                             pulse_valid_o,
  output logic [$clog2(NUM_BINS)-1:0]      pulse_bin_o
);
  import bpla_pkg::*;

  localparam int unsigned BinWidth = $clog2(NUM_BINS);
  localparam int unsigned PosWidth = $clog2(NUM_BINS + 1);

  // held bin request
  logic [15:0] mag_q, spr_q, mmax_q, smax_q;
  logic        clipped_q;
  logic        final_q;

  // run tracking
  logic [PosWidth-1:0] pos_q, pos_d;
  logic                prev_q, prev_d;
  logic [BinWidth-1:0] start_q, start_d;

  logic                pulse_valid_q, pulse_valid_d;
  logic [BinWidth-1:0] pulse_bin_q, pulse_bin_d;

  logic [23:0]         mag_lim, spr_lim;
  logic                hit, in_range, run_end, end_pulse;
  logic [BinWidth-1:0] sel_start;
  logic [PosWidth-1:0] sel_end, span, mid;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mag_q     <= bin_magnitude_i;
      spr_q     <= bin_spread_i;
      mmax_q    <= frame_magnitude_max_i;
      smax_q    <= frame_spread_max_i;
      clipped_q <= frame_clipped_i;
    end
  end

  always_comb begin
    mag_lim  = magnitude_threshold_i * mmax_q;
    spr_lim  = spread_threshold_i * smax_q;
    hit      = ({mag_q, 8'h00} > mag_lim) && ({spr_q, 8'h00} > spr_lim);
    in_range = pos_q < PosWidth'(NUM_BINS);

    prev_d  = prev_q;
    start_d = start_q;
    pos_d   = pos_q;
    run_end = 1'b0;
    if (in_range) begin
      // prev is clear at the first bin, so a run opening there starts at zero
      run_end = prev_q && !hit;
      if (hit && !prev_q) begin
        start_d = BinWidth'(pos_q);
      end
      prev_d = hit;
      pos_d  = pos_q + PosWidth'(1);
    end
    // a run still open at frame end closes on the first bin not delivered
    end_pulse = final_q && prev_d && (pos_d < PosWidth'(NUM_BINS));

    sel_start = run_end ? start_q : start_d;
    sel_end   = run_end ? pos_q : pos_d;
    span      = sel_end - PosWidth'(sel_start);
    mid       = PosWidth'(sel_start) + (span >> 1);

    pulse_valid_d = cmd_i.test && (run_end || end_pulse);
    pulse_bin_d   = BinWidth'(mid);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      final_q       <= 1'b0;
      pos_q         <= '0;
      prev_q        <= 1'b0;
      start_q       <= '0;
      pulse_valid_q <= 1'b0;
    end else begin
      pulse_valid_q <= pulse_valid_d;
      if (cmd_i.accept) begin
        final_q <= final_bin_i;
      end
      if (cmd_i.test) begin
        if (final_q) begin
          pos_q   <= '0;
          prev_q  <= 1'b0;
          start_q <= '0;
        end else begin
          pos_q   <= pos_d;
          prev_q  <= prev_d;
          start_q <= start_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pulse_bin_q <= pulse_bin_d;
  end

  assign final_bin_o     = final_q;
  assign frame_clipped_o = clipped_q;
  assign pulse_valid_o   = pulse_valid_q;
  assign pulse_bin_o     = pulse_bin_q;

endmodule
`default_nettype wire

FILE: src/bpla_lights.sv
// datapath: light ownership, pulse claims, free pulse queue and status register
`timescale 1ns / 1ps
`default_nettype none
module bpla_lights #(
  parameter int unsigned NUM_BINS  = 64,
  parameter int unsigned NUM_LAMPS = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  emit_i,
  input  wire logic                                  pulse_valid_i,
  input  wire logic [$clog2(NUM_BINS)-1:0]           pulse_bin_i,
  input  wire logic                                  frame_clipped_i,
  input  wire logic [7:0]                            decay_reload_i,
  output logic                                       out_free_o,
  output logic                                       emit_last_o,
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  output logic [bpla_pkg::OutDataWidth-1:0]          m_axis_tdata_o,
  output logic                                       m_axis_tlast_o
);
  import bpla_pkg::*;

  localparam int unsigned BinWidth   = $clog2(NUM_BINS);
  localparam int unsigned LampWidth  = (NUM_LAMPS > 1) ? $clog2(NUM_LAMPS) : 1;
  localparam int unsigned CountWidth = $clog2(NUM_LAMPS + 1);

  // light state, rotated one place per emitted status so light idx sits at entry 0
  logic [7:0]          decay_q     [NUM_LAMPS];
  logic [BinWidth-1:0] owned_bin_q [NUM_LAMPS];
  logic                owned_vld_q [NUM_LAMPS];
  logic                took_q      [NUM_LAMPS];

  // unclaimed pulses in ascending bin order, head at entry 0
  logic [BinWidth-1:0]   queue_q [NUM_LAMPS];
  logic [CountWidth-1:0] q_count_q;

  logic [LampWidth-1:0] idx_q;

  logic                 out_valid_q;
  logic [2:0]           out_index_q;
  logic                 out_on_q, out_owned_q, out_last_q;
  logic [5:0]           out_bin_q;
  logic [7:0]           out_decay_q;

  logic [NUM_LAMPS-1:0] match, grant;
  logic                 claimed, push, take, last_light;
  logic [7:0]           new_decay;
  logic [BinWidth-1:0]  new_bin;
  logic                 new_vld, new_lit;

  // owned light whose bin pulsed; the lowest such light wins
  always_comb begin
    for (int i = 0; i < NUM_LAMPS; i++) begin
      match[i] = pulse_valid_i && owned_vld_q[i] && (owned_bin_q[i] == pulse_bin_i);
    end
    grant   = match & (~match + NUM_LAMPS'(1));
    claimed = |match;
    push    = pulse_valid_i && !claimed && (q_count_q < CountWidth'(NUM_LAMPS));
  end

  // resolve the light at entry 0
  always_comb begin
    last_light = idx_q == LampWidth'(NUM_LAMPS - 1);
    take       = (decay_q[0] == 8'd0) && (q_count_q != '0);
    new_bin    = owned_bin_q[0];
    new_vld    = owned_vld_q[0];
    new_decay  = decay_q[0];
    new_lit    = 1'b1;
    if (take) begin
      new_bin   = queue_q[0];
      new_vld   = 1'b1;
      new_decay = decay_reload_i;
    end else if (!took_q[0]) begin
      if (decay_q[0] == 8'd0) begin
        new_vld = 1'b0;
      end else begin
        new_decay = decay_q[0] - 8'd1;
      end
      new_lit = frame_clipped_i && (new_decay < (decay_reload_i >> 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LAMPS; i++) begin
        decay_q[i]     <= 8'd0;
        owned_bin_q[i] <= '0;
        owned_vld_q[i] <= 1'b0;
        took_q[i]      <= 1'b0;
      end
      q_count_q <= '0;
      idx_q     <= '0;
    end else if (emit_i) begin
      for (int i = 0; i < NUM_LAMPS; i++) begin
        if (i == NUM_LAMPS - 1) begin
          decay_q[i]     <= new_decay;
          owned_bin_q[i] <= new_bin;
          owned_vld_q[i] <= new_vld;
          took_q[i]      <= 1'b0;
        end else begin
          decay_q[i]     <= decay_q[(i + 1) % NUM_LAMPS];
          owned_bin_q[i] <= owned_bin_q[(i + 1) % NUM_LAMPS];
          owned_vld_q[i] <= owned_vld_q[(i + 1) % NUM_LAMPS];
          took_q[i]      <= took_q[(i + 1) % NUM_LAMPS];
        end
      end
      if (last_light) begin
        q_count_q <= '0;
        idx_q     <= '0;
      end else begin
        if (take) begin
          q_count_q <= q_count_q - CountWidth'(1);
        end
        idx_q <= idx_q + LampWidth'(1);
      end
    end else begin
      for (int i = 0; i < NUM_LAMPS; i++) begin
        if (grant[i]) begin
          took_q[i]  <= 1'b1;
          decay_q[i] <= decay_reload_i;
        end
      end
      if (push) begin
        q_count_q <= q_count_q + CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      if (take) begin
        for (int i = 0; i < NUM_LAMPS; i++) begin
          queue_q[i] <= queue_q[(i + 1) % NUM_LAMPS];
        end
      end
    end else if (push) begin
      queue_q[q_count_q[LampWidth-1:0]] <= pulse_bin_i;
    end
  end

  // status register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_i) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      out_index_q <= 3'(idx_q);
      out_on_q    <= new_lit;
      out_owned_q <= new_vld;
      out_bin_q   <= new_vld ? 6'(new_bin) : 6'd0;
      out_decay_q <= new_decay;
      out_last_q  <= last_light;
    end
  end

  assign out_free_o      = !out_valid_q || m_axis_tready_i;
  assign emit_last_o     = last_light;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_decay_q, out_bin_q, out_owned_q, out_on_q, out_index_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule
`default_nettype wire

FILE: dv/bpla_light_checker.sv
// checker: predicts the light status requests of each frame and compares them with the block
`timescale 1ns / 1ps
module bpla_light_checker #(
  parameter int unsigned NUM_BINS  = 64,
  parameter int unsigned NUM_LAMPS = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [bpla_pkg::InDataWidth-1:0]    s_axis_tdata_i,
  input  wire logic [0:0]                          s_axis_tuser_i,
  input  wire logic                                s_axis_tlast_i,
  input  wire logic                                s_axis_tvalid_i,
  input  wire logic                                s_axis_tready_i,
  input  wire logic [bpla_pkg::OutDataWidth-1:0]   m_axis_tdata_i,
  input  wire logic                                m_axis_tlast_i,
  input  wire logic                                m_axis_tvalid_i,
  input  wire logic                                m_axis_tready_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [bpla_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  wire logic [bpla_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output int unsigned                              fail_count_o,
  output int unsigned                              pending_o
);

  // status word as laid out on the master tdata, msb first
  typedef struct packed {
    logic [4:0] pad;
    logic [7:0] decay;
    logic [5:0] bin;
    logic       owned;
    logic       on;
    logic [2:0] index;
  } light_status_t;

  typedef struct packed {
    light_status_t status;
    logic          last;
  } light_entry_t;

  logic [7:0]          mag_thr;
  logic [7:0]          spr_thr;
  logic [7:0]          decay_rld;
  logic [NUM_BINS-1:0] triggered;
  logic [NUM_BINS-1:0] pulse;
  int unsigned         bin_pos;
  logic [7:0]          decay_cnt [NUM_LAMPS];
  logic [5:0]          own_bin   [NUM_LAMPS];
  logic [NUM_LAMPS-1:0] own_valid;
  light_entry_t        light_status_q [$];
  int unsigned         fail_count = 0;
  int unsigned         pending = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  task automatic clear_state();
    int unsigned i;
    mag_thr   = bpla_pkg::MAG_THRESHOLD_RST;
    spr_thr   = bpla_pkg::SPR_THRESHOLD_RST;
    decay_rld = bpla_pkg::DECAY_RELOAD_RST;
    triggered = '0;
    pulse     = '0;
    bin_pos   = 0;
    own_valid = '0;
    for (i = 0; i < NUM_LAMPS; i++) begin
      decay_cnt[i] = '0;
      own_bin[i]   = '0;
    end
    light_status_q.delete();
  endtask

  task automatic write_register(input logic [bpla_pkg::CfgIndexWidth-1:0] idx,
                                input logic [7:0] value);
    case (idx)
      bpla_pkg::CFG_MAG_THRESHOLD: mag_thr   = value;
      bpla_pkg::CFG_SPR_THRESHOLD: spr_thr   = value;
      bpla_pkg::CFG_DECAY_RELOAD:  decay_rld = value;
      default: ;
    endcase
  endtask

  // threshold test of one bin; on the final bin the frame's lights are resolved
  task automatic take_bin(input logic [63:0] data, input logic clipped, input logic last);
    logic [31:0]          mag, spr, mmax, smax;
    int unsigned          b, i, start, mid;
    logic [NUM_LAMPS-1:0] took, lit;
    bit                   found;
    light_entry_t         e;
    mag  = {16'd0, data[15:0]};
    spr  = {16'd0, data[31:16]};
    mmax = {16'd0, data[47:32]};
    smax = {16'd0, data[63:48]};
    if (bin_pos < NUM_BINS) begin
      triggered[bin_pos] = (mag * 32'd256 > mmax * mag_thr) && (spr * 32'd256 > smax * spr_thr);
      bin_pos++;
    end
    if (!last) return;

    // bins missing from a short frame count as untriggered
    for (b = bin_pos; b < NUM_BINS; b++) triggered[b] = 1'b0;
    bin_pos = 0;

    // each closed run leaves one pulse at its midpoint
    pulse = '0;
    start = 0;
    for (b = 1; b < NUM_BINS; b++) begin
      if (triggered[b] && !triggered[b-1]) begin
        start = b;
      end else if (!triggered[b] && triggered[b-1]) begin
        mid = start + (b - start) / 2;
        if (mid < NUM_BINS) pulse[mid] = 1'b1;
      end
    end

    took = '0;
    lit  = '0;
    // owned lights keep their bin if it pulsed
    for (i = 0; i < NUM_LAMPS; i++) begin
      if (own_valid[i] && pulse[own_bin[i]]) begin
        took[i]      = 1'b1;
        lit[i]       = 1'b1;
        decay_cnt[i] = decay_rld;
        pulse[own_bin[i]] = 1'b0;
      end
    end
    // free lights take the lowest remaining pulse
    for (i = 0; i < NUM_LAMPS; i++) begin
      if (decay_cnt[i] == 8'd0) begin
        found = 1'b0;
        for (b = 0; b < NUM_BINS; b++) begin
          if (!found && pulse[b]) begin
            found        = 1'b1;
            took[i]      = 1'b1;
            lit[i]       = 1'b1;
            decay_cnt[i] = decay_rld;
            own_bin[i]   = b[5:0];
            own_valid[i] = 1'b1;
            pulse[b]     = 1'b0;
          end
        end
      end
    end
    // the rest go dark, decay and may be relit by a clipped frame
    for (i = 0; i < NUM_LAMPS; i++) begin
      if (!took[i]) begin
        lit[i] = 1'b0;
        if (decay_cnt[i] == 8'd0) own_valid[i] = 1'b0;
        else decay_cnt[i] = decay_cnt[i] - 8'd1;
        if (clipped && decay_cnt[i] < (decay_rld >> 1)) lit[i] = 1'b1;
      end
    end

    for (i = 0; i < NUM_LAMPS; i++) begin
      e.status.pad   = '0;
      e.status.decay = decay_cnt[i];
      e.status.bin   = own_valid[i] ? own_bin[i] : 6'd0;
      e.status.owned = own_valid[i];
      e.status.on    = lit[i];
      e.status.index = i[2:0];
      e.last         = (i == NUM_LAMPS - 1);
      light_status_q.push_back(e);
    end
  endtask

  task automatic check_status(input light_status_t got, input logic got_last);
    light_entry_t want;
    if (light_status_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("light status with none expected: index=%0d on=%0b owned=%0b bin=%0d decay=%0d",
                 got.index, got.on, got.owned, got.bin, got.decay);
      return;
    end
    want = light_status_q.pop_front();
    if (got.index !== want.status.index || got.on !== want.status.on ||
        got.owned !== want.status.owned || got.bin !== want.status.bin ||
        got.decay !== want.status.decay || got.pad !== want.status.pad ||
        got_last !== want.last) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("light status mismatch, expected: index=%0d on=%0b owned=%0b bin=%0d decay=%0d pad=%0h last=%0b",
                 want.status.index, want.status.on, want.status.owned, want.status.bin,
                 want.status.decay, want.status.pad, want.last);
        $display("                       actual:   index=%0d on=%0b owned=%0b bin=%0d decay=%0d pad=%0h last=%0b",
                 got.index, got.on, got.owned, got.bin, got.decay, got.pad, got_last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (cfg_we_i) write_register(cfg_index_i, cfg_data_i);
      if (m_axis_tvalid_i && m_axis_tready_i)
        check_status(light_status_t'(m_axis_tdata_i), m_axis_tlast_i);
      if (s_axis_tvalid_i && s_axis_tready_i)
        take_bin(s_axis_tdata_i, s_axis_tuser_i[0], s_axis_tlast_i);
    end
    pending = light_status_q.size();
  end

endmodule

FILE: dv/beat_pulse_light_assigner_tb.sv
// testbench top: bin frame stimulus, idling phases and verdict for the beat pulse light assigner
`timescale 1ns / 1ps
module beat_pulse_light_assigner_tb;

  localparam int unsigned NumBins   = 64;
  localparam int unsigned NumLamps  = 8;
  // cycles without any request moving before the run is abandoned
  localparam int unsigned IdleLimit = 2000;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic [bpla_pkg::InDataWidth-1:0]   s_data = '0;
  logic [0:0]                         s_user = '0;
  logic                               s_last = 1'b0;
  logic                               s_valid = 1'b0;
  logic                               s_ready;
  logic [bpla_pkg::OutDataWidth-1:0]  m_data;
  logic                               m_last;
  logic                               m_valid;
  logic                               m_ready = 1'b0;
  logic                               cfg_we = 1'b0;
  logic [bpla_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [bpla_pkg::CfgDataWidth-1:0]  cfg_data = '0;

  int unsigned fail_count;
  int unsigned pending;

  // idling odds in percent, set per phase
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  // thresholds in force, used to steer bins either side of the trigger line
  logic [7:0]  cur_mag_thr = bpla_pkg::MAG_THRESHOLD_RST;
  logic [7:0]  cur_spr_thr = bpla_pkg::SPR_THRESHOLD_RST;
  int unsigned bins_sent;
  int unsigned idle_cycles = 0;

  always #5 clk = ~clk;

  beat_pulse_light_assigner #(
    .NUM_BINS (NumBins),
    .NUM_LAMPS(NumLamps)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .s_axis_tlast_i (s_last),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  bpla_light_checker #(
    .NUM_BINS (NumBins),
    .NUM_LAMPS(NumLamps)
  ) checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .s_axis_tlast_i (s_last),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_i(s_ready),
    .m_axis_tdata_i (m_data),
    .m_axis_tlast_i (m_last),
    .m_axis_tvalid_i(m_valid),
    .m_axis_tready_i(m_ready),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // receiver side: stalls at the odds of the current phase
  always @(posedge clk) begin
    m_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: any request accepted on either side restarts the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // all three registers in one burst; write enable stays high across it
  task automatic configure(input logic [7:0] mag_thr, input logic [7:0] spr_thr,
                           input logic [7:0] reload);
    cfg_we    <= 1'b1;
    cfg_index <= bpla_pkg::CFG_MAG_THRESHOLD;
    cfg_data  <= mag_thr;
    @(posedge clk);
    cfg_index <= bpla_pkg::CFG_SPR_THRESHOLD;
    cfg_data  <= spr_thr;
    @(posedge clk);
    cfg_index <= bpla_pkg::CFG_DECAY_RELOAD;
    cfg_data  <= reload;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_mag_thr  = mag_thr;
    cur_spr_thr  = spr_thr;
  endtask

  // one bin request; tvalid only drops when the sender decides to idle
  task automatic send_bin(input logic [15:0] mag, input logic [15:0] spr,
                          input logic [15:0] mmax, input logic [15:0] smax,
                          input logic clip, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {smax, mmax, spr, mag};
    s_user  <= clip;
    s_last  <= last;
    do @(posedge clk); while (!s_ready);
  endtask

  // sender holds off until every light status has come, then lets the block settle
  task automatic drain_lights();
    s_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_max();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return 16'd0;
    if (roll < 15) return 16'hFFFF;
    if (roll < 30) return 16'($urandom_range(255));
    return 16'($urandom);
  endfunction

  function automatic int unsigned pick_frame_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(1, 12);
    if (roll < 90) return $urandom_range(13, 40);
    if (roll < 97) return NumBins;
    return $urandom_range(NumBins + 1, NumBins + 6);
  endfunction

  // a frame of bins: runs of triggered bins with random content, some noise bins
  task automatic random_frame(input int unsigned len);
    logic [15:0] mmax, smax, mag, spr;
    logic [31:0] mag_floor, spr_floor;
    bit          in_run;
    int unsigned n;
    mmax   = pick_max();
    smax   = pick_max();
    in_run = 1'b0;
    for (n = 0; n < len; n++) begin
      in_run    = in_run ? ($urandom_range(99) < 60) : ($urandom_range(99) < 35);
      // largest value that still fails the test
      mag_floor = ({16'd0, mmax} * cur_mag_thr) / 256;
      spr_floor = ({16'd0, smax} * cur_spr_thr) / 256;
      if ($urandom_range(99) < 15) begin
        mag = 16'($urandom);
        spr = 16'($urandom);
        send_bin(mag, spr, 16'($urandom), 16'($urandom), 1'($urandom), n == len - 1);
      end else begin
        if (in_run) begin
          mag = 16'($urandom_range(mag_floor + 1, 32'hFFFF));
          spr = 16'($urandom_range(spr_floor + 1, 32'hFFFF));
        end else if ($urandom_range(1)) begin
          mag = 16'($urandom_range(mag_floor, 0));
          spr = 16'($urandom);
        end else begin
          mag = 16'($urandom);
          spr = 16'($urandom_range(spr_floor, 0));
        end
        send_bin(mag, spr, mmax, smax, 1'($urandom_range(99) < 30), n == len - 1);
      end
      bins_sent++;
    end
  endtask

  // random frames until roughly the item budget of the phase is spent
  task automatic random_phase(input int unsigned budget);
    bins_sent = 0;
    while (bins_sent < budget) begin
      random_frame(pick_frame_len());
      // now and then the sender waits out the whole frame's statuses
      if ($urandom_range(99) < 10) drain_lights();
    end
    drain_lights();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames with the reset thresholds and no idling
    // zero frame maxima: any nonzero bin passes, one run over bins 1 and 2
    send_bin(16'd0,    16'd0,    16'd0, 16'd0, 1'b0, 1'b0);
    send_bin(16'd1,    16'd1,    16'd0, 16'd0, 1'b0, 1'b0);
    send_bin(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b0);
    send_bin(16'd0,    16'd5,    16'd0, 16'd0, 1'b0, 1'b0);
    send_bin(16'd0,    16'd0,    16'd0, 16'd0, 1'b0, 1'b1);
    // run from bin 0, then a run left open at the final bin, clipped frame
    send_bin(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    send_bin(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    send_bin(16'd0,    16'd0,    16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    send_bin(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    send_bin(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    // single-bin frame, clipped: stale pulse marks must not survive
    send_bin(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    // products exactly on the threshold do not trigger
    send_bin(16'd210,  16'hFFFF, 16'd256, 16'd0, 1'b0, 1'b0);
    send_bin(16'd211,  16'd1,    16'd256, 16'd0, 1'b0, 1'b0);
    send_bin(16'd211,  16'd1,    16'd256, 16'd0, 1'b0, 1'b0);
    send_bin(16'd211,  16'd0,    16'd256, 16'd0, 1'b0, 1'b0);
    send_bin(16'd0,    16'd0,    16'd0,   16'd0, 1'b0, 1'b1);
    drain_lights();

    // no idling, mid thresholds, short reservation; opens with an overlong frame
    configure(8'd128, 8'd128, 8'd3);
    random_frame(NumBins + 4);
    random_phase(15);

    // sender idle most of the time, strictest thresholds, one-frame reservation
    idle_pct = 78;
    configure(8'd255, 8'd255, 8'd1);
    random_phase(10);

    // both sides idle a little, zero reload taken literally
    idle_pct  = 7;
    stall_pct = 7;
    configure(8'd230, 8'd200, 8'd0);
    random_phase(10);

    // receiver stalling most of the time, loosest thresholds, longest reservation
    idle_pct  = 0;
    stall_pct = 78;
    configure(8'd0, 8'd0, 8'd255);
    random_phase(10);

    // back to the reset settings with no idling
    stall_pct = 0;
    configure(bpla_pkg::MAG_THRESHOLD_RST, bpla_pkg::SPR_THRESHOLD_RST,
              bpla_pkg::DECAY_RELOAD_RST);
    random_phase(10);

    repeat (12) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
